>>> sv/stall_load_drop_detector_defines.svh
// assertion macros for the stall load drop detector checker
// expects clk and arst_n in the scope of every use

`ifndef STALL_LOAD_DROP_DETECTOR_DEFINES_SVH
`define STALL_LOAD_DROP_DETECTOR_DEFINES_SVH

// same-cycle implication
`define SLD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sld_pkg.sv
// shared types, widths, register codes and reset values of the stall detector
// no dependencies

`default_nettype none

package sld_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int COUNT_BITS  = 10;
	localparam int VALUE_W     = SAMPLE_BITS + 8;
	localparam int TIME_W      = 32;
	localparam int POS_W       = 32;
	localparam int DROP_W      = 9;
	localparam int POLL_W      = 10;
	localparam int IGN_W       = 16;
	localparam int BWIN_W      = 16;
	localparam int FLOOR_W     = 10;
	localparam int TRAVEL_W    = 20;
	localparam int MUL_B_W     = (COUNT_BITS > DROP_W) ? COUNT_BITS : DROP_W;
	localparam int PROD_W      = VALUE_W + MUL_B_W;
	localparam int NUM_W       = VALUE_W + COUNT_BITS + 1;
	localparam int DIV_STEPS   = 2;
	localparam int DIV_W       = ((NUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int DIV_CYC     = DIV_W / DIV_STEPS;
	localparam int DIV_CNT_W   = $clog2(DIV_CYC + 1);
	localparam int CMP_W       = VALUE_W + 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [VALUE_W-1:0]     value_t;
	typedef logic [VALUE_W+1:0]     ema_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [COUNT_BITS:0]    trial_t;
	typedef logic [TIME_W-1:0]      time_t;
	typedef logic [POS_W:0]         delta_t;
	typedef logic [MUL_B_W-1:0]     mulb_t;
	typedef logic [PROD_W-1:0]      prod_t;
	typedef logic [NUM_W-1:0]       num_t;
	typedef logic [DIV_W-1:0]       divw_t;
	typedef logic [DIV_CNT_W-1:0]   divcnt_t;
	typedef logic [CMP_W-1:0]       cmp_t;
	typedef logic [DROP_W-1:0]      drop_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	localparam cfg_idx_t REG_POLL   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_IGNORE = cfg_idx_t'(1);
	localparam cfg_idx_t REG_BWIN   = cfg_idx_t'(2);
	localparam cfg_idx_t REG_DROP   = cfg_idx_t'(3);
	localparam cfg_idx_t REG_FLOOR  = cfg_idx_t'(4);
	localparam cfg_idx_t REG_TRAVEL = cfg_idx_t'(5);

	localparam logic [POLL_W-1:0]   POLL_RST   = POLL_W'(10);
	localparam logic [IGN_W-1:0]    IGN_RST    = IGN_W'(50);
	localparam logic [BWIN_W-1:0]   BWIN_RST   = BWIN_W'(200);
	localparam drop_t               DROP_RST   = drop_t'(90);
	localparam logic [FLOOR_W-1:0]  FLOOR_RST  = FLOOR_W'(0);
	localparam logic [TRAVEL_W-1:0] TRAVEL_RST = TRAVEL_W'(1200);

	localparam drop_t  FULL_SCALE   = drop_t'(256);
	localparam count_t COUNT_MAX    = {COUNT_BITS{1'b1}};
	localparam count_t COUNT_ONE    = count_t'(1);
	localparam count_t AVG_FOLLOW_N = count_t'(3);
	localparam count_t STALL_MIN_N  = count_t'(5);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_THR,
		ST_SCALE,
		ST_DONE
	} seq_state_t;

endpackage

`default_nettype wire

>>> sv/sld_if.sv
// valid/ready channel interfaces for load items and result items
// depends on sld_pkg

`default_nettype none

interface sld_load_if;
	logic                 valid;
	logic                 ready;
	logic                 restart;
	sld_pkg::time_t       now_ms;
	sld_pkg::sample_t     load_sample;
	logic signed [sld_pkg::POS_W-1:0] axis_position;

	modport source (output valid, restart, now_ms, load_sample, axis_position, input ready);
	modport sink (input valid, restart, now_ms, load_sample, axis_position, output ready);
endinterface

interface sld_result_if;
	logic            valid;
	logic            ready;
	logic            stall_res;
	logic            sample_taken;
	sld_pkg::value_t average_q8;
	sld_pkg::value_t baseline_q8;
	logic            active;

	modport source (output valid, stall_res, sample_taken, average_q8, baseline_q8, active,
		input ready);
	modport sink (input valid, stall_res, sample_taken, average_q8, baseline_q8, active,
		output ready);
endinterface

`default_nettype wire

>>> sv/sld_serial_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle, stops early on zero
// depends on sld_pkg

`default_nettype none

module sld_serial_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sld_pkg::value_t  mcand,
	input  sld_pkg::mulb_t   mplier,
	output logic             done,
	output sld_pkg::prod_t   prod
);

	logic           busy_q;
	logic           done_q;
	sld_pkg::prod_t acc_q;
	sld_pkg::prod_t mc_q;
	sld_pkg::mulb_t mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && (mp_q == '0)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= sld_pkg::prod_t'(mcand);
			mp_q  <= mplier;
		end else if (busy_q && (mp_q != '0)) begin
			acc_q <= acc_q + (mp_q[0] ? mc_q : '0);
			mc_q  <= {mc_q[sld_pkg::PROD_W-2:0], 1'b0};
			mp_q  <= {1'b0, mp_q[sld_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

>>> sv/sld_serial_div.sv
// restoring divider, two quotient bits per cycle, for the running-mean update
// depends on sld_pkg

`default_nettype none

module sld_serial_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sld_pkg::num_t    num,
	input  sld_pkg::count_t  den,
	output logic             done,
	output sld_pkg::value_t  quo
);

	logic             busy_q;
	logic             done_q;
	sld_pkg::divcnt_t cnt_q;
	sld_pkg::divw_t   sh_q;
	sld_pkg::count_t  rem_q;
	sld_pkg::count_t  den_q;
	sld_pkg::divw_t   sh_d;
	sld_pkg::count_t  rem_d;

	always_comb begin
		sld_pkg::trial_t t;
		sh_d  = sh_q;
		rem_d = rem_q;
		for (int i = 0; i < sld_pkg::DIV_STEPS; i++) begin
			t    = {rem_d, sh_d[sld_pkg::DIV_W-1]};
			sh_d = {sh_d[sld_pkg::DIV_W-2:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				rem_d   = sld_pkg::count_t'(t - {1'b0, den_q});
				sh_d[0] = 1'b1;
			end else begin
				rem_d = t[sld_pkg::COUNT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= sld_pkg::divcnt_t'(sld_pkg::DIV_CYC);
		end else if (busy_q) begin
			cnt_q <= cnt_q - sld_pkg::divcnt_t'(1);
			if (cnt_q == sld_pkg::divcnt_t'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= sld_pkg::divw_t'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= sh_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign quo  = sh_q[sld_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

>>> sv/stall_load_drop_detector.sv
// Stall detector on a drop in motor load.
// load_ch (sink) takes one item per transfer: restart, now_ms, load_sample,
// axis_position. result_ch (source) gives exactly one result per item:
// stall_res, sample_taken, average_q8, baseline_q8, active.
// Configuration: cfg_wen with cfg_idx and cfg_data writes one register per
// cycle; user must write only while no item is in flight (not enforced).
// One item is worked at a time; load_ch.ready is high only when idle.
// States from input transfer to result valid: IDLE, PREP, CHECK, then
//   inactive phase              DONE
//   no sample or EMA update     THR, SCALE if stall test runs, DONE
//   baseline update             MUL, DIV, THR, SCALE if stall test runs, DONE
// The running-mean divide (two quotient bits per cycle) and the bit-serial
// multiplier (one bit per cycle) set the time spent in DIV, MUL and SCALE.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the block only when the next result is
// ready to be written.
// Reset (arst_n low) clears the phase state and loads the register defaults.
// depends on sld_pkg, sld_if, sld_serial_mul, sld_serial_div

`default_nettype none

module stall_load_drop_detector (
	input  logic                       clk,
	input  logic                       arst_n,
	sld_load_if.sink                   load_ch,
	sld_result_if.source               result_ch,
	input  logic                       cfg_wen,
	input  sld_pkg::cfg_idx_t          cfg_idx,
	input  logic [sld_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [sld_pkg::POLL_W-1:0]   poll_q;
	logic [sld_pkg::IGN_W-1:0]    ign_q;
	logic [sld_pkg::BWIN_W-1:0]   bwin_q;
	sld_pkg::drop_t               drop_q;
	logic [sld_pkg::FLOOR_W-1:0]  floor_q;
	logic [sld_pkg::TRAVEL_W-1:0] travel_q;

	// captured item
	logic                            restart_q;
	sld_pkg::time_t                  now_q;
	sld_pkg::sample_t                raw_q;
	logic [sld_pkg::POS_W-1:0]       pos_q;

	// phase state
	logic                      active_q;
	sld_pkg::time_t            start_time_q;
	sld_pkg::time_t            last_poll_q;
	sld_pkg::count_t           count_q;
	sld_pkg::value_t           base_q;
	sld_pkg::value_t           avg_q;
	logic [sld_pkg::POS_W-1:0] start_pos_q;

	// per item flags
	logic            taken_q;
	logic            stall_q;
	logic            past_ign_q;
	sld_pkg::delta_t delta_q;

	// output register
	logic            out_valid_q;
	logic            out_stall_q;
	logic            out_taken_q;
	sld_pkg::value_t out_avg_q;
	sld_pkg::value_t out_base_q;
	logic            out_active_q;

	sld_pkg::seq_state_t state_q;
	sld_pkg::seq_state_t state_d;

	logic            mul_start;
	sld_pkg::mulb_t  mul_mplier;
	logic            mul_done;
	sld_pkg::prod_t  mul_prod;
	logic            div_start;
	sld_pkg::num_t   div_num;
	logic            div_done;
	sld_pkg::value_t div_quo;

	sld_pkg::time_t  age;
	sld_pkg::time_t  poll_gap;
	logic            poll_ok;
	logic            in_win;
	logic            past_ign;
	logic            do_mean;
	logic            do_eval;
	logic            out_load;
	sld_pkg::count_t cnt_inc;
	sld_pkg::delta_t delta_d;
	sld_pkg::ema_t   ema_sum;
	sld_pkg::drop_t  drop_sat;
	sld_pkg::cmp_t   rel_c;
	sld_pkg::cmp_t   flo_c;
	sld_pkg::cmp_t   thr_c;
	logic            avg_low;
	sld_pkg::delta_t min_ext;
	sld_pkg::delta_t neg_sum;
	logic            dist_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q   <= sld_pkg::POLL_RST;
			ign_q    <= sld_pkg::IGN_RST;
			bwin_q   <= sld_pkg::BWIN_RST;
			drop_q   <= sld_pkg::DROP_RST;
			floor_q  <= sld_pkg::FLOOR_RST;
			travel_q <= sld_pkg::TRAVEL_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				sld_pkg::REG_POLL:   poll_q   <= cfg_data[sld_pkg::POLL_W-1:0];
				sld_pkg::REG_IGNORE: ign_q    <= cfg_data[sld_pkg::IGN_W-1:0];
				sld_pkg::REG_BWIN:   bwin_q   <= cfg_data[sld_pkg::BWIN_W-1:0];
				sld_pkg::REG_DROP:   drop_q   <= cfg_data[sld_pkg::DROP_W-1:0];
				sld_pkg::REG_FLOOR:  floor_q  <= cfg_data[sld_pkg::FLOOR_W-1:0];
				sld_pkg::REG_TRAVEL: travel_q <= cfg_data[sld_pkg::TRAVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// per item arithmetic
	always_comb begin
		age      = now_q - start_time_q;
		poll_gap = now_q - last_poll_q;
		poll_ok  = poll_gap >= sld_pkg::time_t'(poll_q);
		in_win   = age <= sld_pkg::time_t'(bwin_q);
		past_ign = age > sld_pkg::time_t'(ign_q);
		do_mean  = active_q && poll_ok && in_win;
		do_eval  = past_ign_q && (count_q > sld_pkg::STALL_MIN_N);
		cnt_inc  = (count_q == sld_pkg::COUNT_MAX) ? count_q : count_q + sld_pkg::COUNT_ONE;
		delta_d  = {pos_q[sld_pkg::POS_W-1], pos_q} - {start_pos_q[sld_pkg::POS_W-1], start_pos_q};
		ema_sum  = sld_pkg::ema_t'({raw_q, 8'b0}) + sld_pkg::ema_t'(avg_q)
			+ sld_pkg::ema_t'({avg_q, 1'b0});
		drop_sat = (drop_q > sld_pkg::FULL_SCALE) ? sld_pkg::FULL_SCALE : drop_q;
		div_num  = {1'b0, mul_prod[sld_pkg::VALUE_W+sld_pkg::COUNT_BITS-1:0]}
			+ sld_pkg::num_t'({raw_q, 8'b0});
		rel_c    = sld_pkg::cmp_t'(mul_prod[sld_pkg::VALUE_W+8:8]);
		flo_c    = sld_pkg::cmp_t'({floor_q, 8'b0});
		thr_c    = (rel_c > flo_c) ? rel_c : flo_c;
		avg_low  = sld_pkg::cmp_t'(avg_q) <= thr_c;
		min_ext  = sld_pkg::delta_t'(travel_q);
		neg_sum  = delta_q + min_ext;
		dist_ok  = delta_q[sld_pkg::POS_W]
			? (neg_sum[sld_pkg::POS_W] || (neg_sum == '0))
			: (delta_q >= min_ext);
		out_load = (state_q == sld_pkg::ST_DONE) && (!out_valid_q || result_ch.ready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sld_pkg::ST_IDLE:  if (load_ch.valid) state_d = sld_pkg::ST_PREP;
			sld_pkg::ST_PREP:  state_d = sld_pkg::ST_CHECK;
			sld_pkg::ST_CHECK: begin
				if (!active_q) state_d = sld_pkg::ST_DONE;
				else if (do_mean) state_d = sld_pkg::ST_MUL;
				else state_d = sld_pkg::ST_THR;
			end
			sld_pkg::ST_MUL:   if (mul_done) state_d = sld_pkg::ST_DIV;
			sld_pkg::ST_DIV:   if (div_done) state_d = sld_pkg::ST_THR;
			sld_pkg::ST_THR:   state_d = do_eval ? sld_pkg::ST_SCALE : sld_pkg::ST_DONE;
			sld_pkg::ST_SCALE: if (mul_done) state_d = sld_pkg::ST_DONE;
			sld_pkg::ST_DONE:  if (out_load) state_d = sld_pkg::ST_IDLE;
			default:           state_d = sld_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		load_ch.ready = 1'b0;
		mul_start     = 1'b0;
		mul_mplier    = '0;
		div_start     = 1'b0;
		case (state_q)
			sld_pkg::ST_IDLE:  load_ch.ready = 1'b1;
			sld_pkg::ST_CHECK: begin
				mul_start  = do_mean;
				mul_mplier = sld_pkg::mulb_t'(cnt_inc - sld_pkg::COUNT_ONE);
			end
			sld_pkg::ST_MUL:   div_start = mul_done;
			sld_pkg::ST_THR: begin
				mul_start  = do_eval;
				mul_mplier = sld_pkg::mulb_t'(sld_pkg::FULL_SCALE - drop_sat);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sld_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	sld_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (base_q),
		.mplier (mul_mplier),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	sld_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (count_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// item capture and per item flags
	always_ff @(posedge clk) begin
		if (state_q == sld_pkg::ST_IDLE && load_ch.valid) begin
			restart_q <= load_ch.restart;
			now_q     <= load_ch.now_ms;
			raw_q     <= load_ch.load_sample;
			pos_q     <= load_ch.axis_position;
		end
		if (state_q == sld_pkg::ST_CHECK) begin
			past_ign_q <= past_ign;
			delta_q    <= delta_d;
		end
	end

	// phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			start_time_q <= '0;
			last_poll_q  <= '0;
			count_q      <= '0;
			base_q       <= '0;
			avg_q        <= '0;
			start_pos_q  <= '0;
			taken_q      <= 1'b0;
			stall_q      <= 1'b0;
		end else begin
			case (state_q)
				sld_pkg::ST_PREP: begin
					if (restart_q) begin
						active_q     <= 1'b1;
						start_time_q <= now_q;
						start_pos_q  <= pos_q;
						last_poll_q  <= '0;
						count_q      <= '0;
						base_q       <= '0;
						avg_q        <= '0;
					end
				end
				sld_pkg::ST_CHECK: begin
					taken_q <= active_q && poll_ok;
					stall_q <= 1'b0;
					if (active_q && poll_ok) begin
						last_poll_q <= now_q;
						if (in_win) begin
							count_q <= cnt_inc;
						end else begin
							avg_q <= ema_sum[sld_pkg::VALUE_W+1:2];
						end
					end
				end
				sld_pkg::ST_DIV: begin
					if (div_done) begin
						base_q <= div_quo;
						if (count_q < sld_pkg::AVG_FOLLOW_N) avg_q <= div_quo;
					end
				end
				sld_pkg::ST_SCALE: begin
					if (mul_done && avg_low && dist_ok) begin
						stall_q  <= 1'b1;
						active_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_stall_q  <= stall_q;
			out_taken_q  <= taken_q;
			out_avg_q    <= avg_q;
			out_base_q   <= base_q;
			out_active_q <= active_q;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.stall_res    = out_stall_q;
	assign result_ch.sample_taken = out_taken_q;
	assign result_ch.average_q8   = out_avg_q;
	assign result_ch.baseline_q8  = out_base_q;
	assign result_ch.active       = out_active_q;

endmodule

`default_nettype wire

>>> sv/sld_checker.sv
// port-level checks of the stall detector, bound to the top level
// depends on sld_pkg and stall_load_drop_detector_defines.svh

`default_nettype none

`include "stall_load_drop_detector_defines.svh"

module sld_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic            stall_res,
	input wire logic            sample_taken,
	input wire sld_pkg::value_t average_q8,
	input wire sld_pkg::value_t baseline_q8,
	input wire logic            active
);

	// a stall always closes the phase
	`SLD_ASSERT_SAME(a_stall_closes, out_valid && stall_res, !active, "stall with phase active")

	// no sample is taken by an item that leaves no live phase behind and did not stall
	`SLD_ASSERT_SAME(a_idle_no_sample, out_valid && !active && !stall_res, !sample_taken,
		"sample taken while phase inactive")

	// one item in flight at a time
	`SLD_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "ready right after transfer")

	// a waiting result holds
	`SLD_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
		out_valid && $stable(stall_res) && $stable(sample_taken) && $stable(average_q8) && $stable(baseline_q8) && $stable(active),
		"result changed while stalled")

endmodule

bind stall_load_drop_detector sld_checker u_sld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (load_ch.valid),
	.in_ready     (load_ch.ready),
	.out_valid    (result_ch.valid),
	.out_ready    (result_ch.ready),
	.stall_res    (result_ch.stall_res),
	.sample_taken (result_ch.sample_taken),
	.average_q8   (result_ch.average_q8),
	.baseline_q8  (result_ch.baseline_q8),
	.active       (result_ch.active)
);

`default_nettype wire

>>> tb/stall_load_drop_detector_test.sv
`timescale 1ns / 1ps
// self-checking bench for stall_load_drop_detector: directed and random load items
// checked against an in-bench tracker of baseline, average and stall decisions
// depends on sld_pkg, sld_if and the detector rtl

module stall_load_drop_detector_test;
	import sld_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SAT_COUNT = (1 << COUNT_BITS) - 1;
	localparam int FOLLOW_N = 3;
	localparam int MIN_SAMPLES = 5;
	localparam int FULL_DROP = 256;

	typedef struct {
		logic                 restart;
		time_t                now;
		sample_t              load;
		logic signed [POS_W-1:0] pos;
	} load_item_t;

	typedef struct {
		logic   stall;
		logic   taken;
		value_t avg;
		value_t base;
		logic   active;
	} stall_out_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	cfg_idx_t cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	sld_load_if load_ch();
	sld_result_if result_ch();

	stall_load_drop_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.load_ch(load_ch),
		.result_ch(result_ch),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// register copies
	logic [POLL_W-1:0]   poll_ms    = POLL_W'(10);
	logic [IGN_W-1:0]    ignore_ms  = IGN_W'(50);
	logic [BWIN_W-1:0]   bwin_ms    = BWIN_W'(200);
	logic [DROP_W-1:0]   drop_q8    = DROP_W'(90);
	logic [FLOOR_W-1:0]  floor_raw  = FLOOR_W'(0);
	logic [TRAVEL_W-1:0] travel_min = TRAVEL_W'(1200);

	// tracked phase state
	logic    m_active = 1'b0;
	time_t   m_start_ms = '0;
	time_t   m_last_poll_ms = '0;
	count_t  m_count = '0;
	value_t  m_baseline = '0;
	value_t  m_average = '0;
	logic signed [POS_W-1:0] m_start_pos = '0;

	load_item_t load_items_todo[$];
	stall_out_t stall_reports_due[$];
	load_item_t on_wire;
	int mismatches = 0;
	int items_made = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_rx = 1'b0;

	function automatic stall_out_t track_load_drop(input load_item_t it);
		stall_out_t o;
		time_t age;
		value_t scaled;
		logic [63:0] wide;
		logic [DROP_W-1:0] d;
		logic [63:0] rel;
		logic [63:0] flo;
		logic [63:0] thr;
		longint delta;
		o = '{stall: 1'b0, taken: 1'b0, avg: '0, base: '0, active: 1'b0};
		if (it.restart) begin
			m_active = 1'b1;
			m_start_ms = it.now;
			m_start_pos = it.pos;
			m_last_poll_ms = '0;
			m_count = '0;
			m_baseline = '0;
			m_average = '0;
		end
		if (m_active) begin
			age = it.now - m_start_ms;
			scaled = {it.load, 8'h00};
			if (time_t'(it.now - m_last_poll_ms) >= time_t'(poll_ms)) begin
				o.taken = 1'b1;
				m_last_poll_ms = it.now;
				if (age <= time_t'(bwin_ms)) begin
					if (int'(m_count) < SAT_COUNT)
						m_count = m_count + 1'b1;
					wide = (64'(m_baseline) * 64'(int'(m_count) - 1) + 64'(scaled))
						/ 64'(m_count);
					m_baseline = value_t'(wide);
					if (int'(m_count) < FOLLOW_N)
						m_average = m_baseline;
				end else begin
					m_average = value_t'((64'(scaled) + 64'(3) * 64'(m_average)) >> 2);
				end
			end
			if (age > time_t'(ignore_ms) && int'(m_count) > MIN_SAMPLES) begin
				d = (int'(drop_q8) > FULL_DROP) ? DROP_W'(FULL_DROP) : drop_q8;
				rel = (64'(m_baseline) * (64'(FULL_DROP) - 64'(d))) >> 8;
				flo = 64'(floor_raw) << 8;
				thr = (rel > flo) ? rel : flo;
				if (64'(m_average) <= thr) begin
					delta = longint'(it.pos) - longint'(m_start_pos);
					if (delta < 0)
						delta = -delta;
					if (delta >= longint'(travel_min)) begin
						o.stall = 1'b1;
						m_active = 1'b0;
					end
				end
			end
		end
		o.avg = m_average;
		o.base = m_baseline;
		o.active = m_active;
		return o;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// load driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ch.valid <= 1'b0;
			load_ch.restart <= 1'b0;
			load_ch.now_ms <= '0;
			load_ch.load_sample <= '0;
			load_ch.axis_position <= '0;
		end else begin
			if (load_ch.valid && load_ch.ready)
				stall_reports_due.push_back(track_load_drop(on_wire));
			if (!load_ch.valid || load_ch.ready) begin
				if (load_items_todo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					on_wire = load_items_todo.pop_front();
					load_ch.valid <= 1'b1;
					load_ch.restart <= on_wire.restart;
					load_ch.now_ms <= on_wire.now;
					load_ch.load_sample <= on_wire.load;
					load_ch.axis_position <= on_wire.pos;
				end else begin
					load_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		stall_out_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (stall_reports_due.size() == 0) begin
				flag_mismatch("result with none due", result_ch.average_q8, -1);
			end else begin
				want = stall_reports_due.pop_front();
				if (result_ch.stall_res !== want.stall)
					flag_mismatch("stall_res", result_ch.stall_res, want.stall);
				if (result_ch.sample_taken !== want.taken)
					flag_mismatch("sample_taken", result_ch.sample_taken, want.taken);
				if (result_ch.average_q8 !== want.avg)
					flag_mismatch("average_q8", result_ch.average_q8, want.avg);
				if (result_ch.baseline_q8 !== want.base)
					flag_mismatch("baseline_q8", result_ch.baseline_q8, want.base);
				if (result_ch.active !== want.active)
					flag_mismatch("active", result_ch.active, want.active);
			end
		end
	end

	task automatic queue_load(input logic rs, input time_t t, input sample_t ld,
			input logic signed [POS_W-1:0] p);
		load_item_t it;
		it.restart = rs;
		it.now = t;
		it.load = ld;
		it.pos = p;
		load_items_todo.push_back(it);
		items_made++;
	endtask

	task automatic set_reg(input cfg_idx_t idx, input int unsigned value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DATA_W'(value);
		case (idx)
			REG_POLL:   poll_ms = POLL_W'(value);
			REG_IGNORE: ignore_ms = IGN_W'(value);
			REG_BWIN:   bwin_ms = BWIN_W'(value);
			REG_DROP:   drop_q8 = DROP_W'(value);
			REG_FLOOR:  floor_raw = FLOOR_W'(value);
			REG_TRAVEL: travel_min = TRAVEL_W'(value);
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic drain();
		while (load_items_todo.size() != 0 || load_ch.valid || stall_reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// restart, then samples near the poll rate with a load drop part way through
	task automatic homing_run(input int len);
		time_t t;
		logic signed [POS_W-1:0] p;
		logic rs;
		int level;
		int cut;
		int speed;
		int dir;
		int dt;
		int pick;
		int v;
		t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom();
		p = $urandom();
		dir = $urandom_range(0, 1) ? 1 : -1;
		speed = $urandom_range(0, 60);
		level = $urandom_range(200, 1023);
		cut = $urandom_range(3, len);
		queue_load(1'b1, t, sample_t'(level), p);
		for (int k = 1; k < len; k++) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				dt = 0;
			else if (pick == 1)
				dt = $urandom_range(0, poll_ms);
			else if (pick == 2)
				dt = $urandom_range(0, int'(bwin_ms) + int'(ignore_ms) + 50);
			else
				dt = int'(poll_ms) + $urandom_range(0, 2);
			t = t + time_t'(dt);
			p = p + dir * speed * dt;
			if (k < cut)
				v = level + int'($urandom_range(0, 40)) - 20;
			else
				v = level * int'($urandom_range(0, 70)) / 100;
			if (v > 1023)
				v = 1023;
			if (v < 0)
				v = 0;
			rs = ($urandom_range(0, 40) == 0);
			queue_load(rs, t, sample_t'(v), p);
		end
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 4);
		repeat (n)
			queue_load(1'($urandom_range(0, 1)), $urandom(),
				sample_t'($urandom_range(0, 1023)), $urandom());
	endtask

	// enough baseline samples in one phase to pin the sample counter
	task automatic fill_saturation();
		time_t t;
		logic signed [POS_W-1:0] p;
		t = $urandom();
		p = $urandom();
		queue_load(1'b1, t, sample_t'($urandom_range(0, 1023)), p);
		repeat (SAT_COUNT + 12) begin
			t = t + $urandom_range(0, 1);
			p = p + int'($urandom_range(0, 8)) - 4;
			queue_load(1'b0, t, sample_t'($urandom_range(0, 1023)), p);
		end
		for (int k = 0; k < 5; k++) begin
			t = t + 70000 + k;
			queue_load(1'b0, t, sample_t'(0), $urandom());
		end
	endtask

	task automatic run_phase(input int unsigned poll, ign, bwin, drop, flr, travel,
			input int tx, rx, target, input bit squeeze, saturate);
		int goal;
		set_reg(REG_POLL, poll);
		set_reg(REG_IGNORE, ign);
		set_reg(REG_BWIN, bwin);
		set_reg(REG_DROP, drop);
		set_reg(REG_FLOOR, flr);
		set_reg(REG_TRAVEL, travel);
		@(negedge clk);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		if (squeeze) begin
			fork
				begin
					hold_rx = 1'b1;
					repeat (LONG_HOLD_CYCLES) @(negedge clk);
					hold_rx = 1'b0;
				end
			join_none
		end
		goal = items_made + target;
		if (saturate)
			fill_saturation();
		while (items_made < goal) begin
			if ($urandom_range(0, 4) == 0)
				noise_burst();
			else
				homing_run($urandom_range(8, 60));
		end
		drain();
	endtask

	initial begin
		time_t t0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = REG_POLL;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on the reset register values
		t0 = 32'hFFFF_FFF6;
		queue_load(1'b0, 32'h0000_1234, 10'h3FF, 32'sh0000_0100);
		queue_load(1'b1, 32'h0000_0000, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, 32'h0000_0005, 10'h3FF, 32'sh8000_0000);
		queue_load(1'b1, t0, 10'h3FF, 32'sh7FFF_FFFF);
		queue_load(1'b0, t0 + 10, 10'h3FF, 32'sh7FFF_FFFF);
		queue_load(1'b0, t0 + 20, 10'h200, 32'sh7FFF_0000);
		queue_load(1'b0, t0 + 30, 10'h001, 32'sh4000_0000);
		queue_load(1'b0, t0 + 40, 10'h000, 32'sh0000_0000);
		queue_load(1'b0, t0 + 50, 10'h3FF, 32'shC000_0000);
		queue_load(1'b0, t0 + 60, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, t0 + 65, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, t0 + 250, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, t0 + 260, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, t0 + 270, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, t0 + 280, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, t0 + 290, 10'h000, 32'sh8000_0000);
		queue_load(1'b0, 32'hFFFF_FFFF, 10'h3FF, 32'sh7FFF_FFFF);
		queue_load(1'b1, 32'h0000_1000, 10'h155, 32'sh0000_0000);
		for (int k = 1; k <= 6; k++)
			queue_load(1'b0, 32'h0000_1000 + 10 * k, 10'h000, 32'sh0000_0000);
		drain();

		run_phase(10, 50, 200, 90, 0, 1200, 0, 0, 10, 1'b0, 1'b0);
		run_phase(0, 0, 0, 0, 1023, 0, 83, 0, 10, 1'b0, 1'b0);
		run_phase(1000, 65535, 65535, 256, 0, 1048575, 0, 83, 10, 1'b0, 1'b0);
		run_phase(0, 65535, 65535, 90, 1023, 0, 0, 0, 0, 1'b0, 1'b1);
		run_phase(3, 20, 60, 511, 512, 100, 0, 35, 10, 1'b1, 1'b0);
		run_phase(25, 100, 300, 200, 100, 5000, 35, 35, 10, 1'b0, 1'b0);
		run_phase(1, 5, 40, 128, 300, 50, 83, 83, 10, 1'b0, 1'b0);
		run_phase(10, 50, 200, 90, 0, 1200, 35, 35, 10, 1'b0, 1'b0);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
